// ===== src/pfba_pkg.sv =====
// Package: constants, types and state codes of the page frame bitmap allocator.
package pfba_pkg;

	// Frame count; a multiple of 1024 (sixteen 64-bit map words per scan group).
	localparam int NUM_FRAMES  = 16384;
	localparam int FRAME_SHIFT = 12;
	localparam int WORD_BITS   = 64;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int FRAME_W     = $clog2(NUM_FRAMES);
	localparam int MAP_WORDS   = NUM_FRAMES / WORD_BITS;
	localparam int WORD_W      = $clog2(MAP_WORDS);
	localparam int GRP_WORDS   = 16;
	localparam int GRP_SEL_W   = $clog2(GRP_WORDS);
	localparam int NUM_GRPS    = MAP_WORDS / GRP_WORDS;
	localparam int GRP_W       = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;

	// Input field widths
	localparam int KIND_W = 2;
	localparam int ADDR_W = 27;
	localparam int FA_W   = 26;
	localparam int STEP_W = ADDR_W + 1 - FRAME_SHIFT;
	// Frame-number arithmetic of a range; wide enough for first + steps.
	localparam int RNG_W  = 21;

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	typedef logic [WORD_BITS-1:0] map_word_t;

	// Control to the shared word unit
	typedef struct packed {
		logic             alloc;
		logic             set;
		logic [BIT_W-1:0] lo;
		logic [BIT_W-1:0] hi;
	} pfba_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_LIMIT,
		ST_SCAN,
		ST_RD,
		ST_MOD,
		ST_DONE
	} pfba_state_t;

endpackage

// ===== src/pfba_word_unit.sv =====
// Shared word unit: first-free-bit search and masked set/clear of one map word.
module pfba_word_unit (
	input  pfba_pkg::map_word_t            word_in,
	input  pfba_pkg::pfba_op_t             op,
	output pfba_pkg::map_word_t            word_out,
	output logic [pfba_pkg::BIT_W-1:0]     free_bit
);

	pfba_pkg::map_word_t mask;
	logic                found;

	// lowest zero bit
	always_comb begin
		found    = 1'b0;
		free_bit = '0;
		for (int b = 0; b < pfba_pkg::WORD_BITS; b++) begin
			if (!found && !word_in[b]) begin
				found    = 1'b1;
				free_bit = pfba_pkg::BIT_W'(b);
			end
		end
	end

	always_comb begin
		for (int b = 0; b < pfba_pkg::WORD_BITS; b++) begin
			mask[b] = (pfba_pkg::BIT_W'(b) >= op.lo) && (pfba_pkg::BIT_W'(b) <= op.hi);
		end
	end

	always_comb begin
		if (op.alloc) begin
			word_out = word_in | (pfba_pkg::map_word_t'(1) << free_bit);
		end else if (op.set) begin
			word_out = word_in | mask;
		end else begin
			word_out = word_in & ~mask;
		end
	end

endmodule

// ===== src/pfba_map.sv =====
// Bitmap store: word memory with per-word valid and full flags.
module pfba_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [pfba_pkg::WORD_W-1:0]  rd_addr,
	output pfba_pkg::map_word_t          rd_data,
	input  logic                         wr_en,
	input  logic [pfba_pkg::WORD_W-1:0]  wr_addr,
	input  pfba_pkg::map_word_t          wr_data,
	output logic [pfba_pkg::MAP_WORDS-1:0] full
);

	pfba_pkg::map_word_t mem [pfba_pkg::MAP_WORDS];
	pfba_pkg::map_word_t rd_word_q;
	logic                rd_vld_q;
	logic [pfba_pkg::MAP_WORDS-1:0] valid_q;
	logic [pfba_pkg::MAP_WORDS-1:0] full_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// never-written words read as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			full_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				full_q[wr_addr]  <= &wr_data;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;
	assign full    = full_q;

endmodule

// ===== src/page_frame_bitmap_allocator_top.sv =====
// Top level of the first-fit page frame bitmap allocator.
// One used/free bit per 4 KiB frame, 16384 frames (64 MiB), held as 256 words of 64 bits in a
// single-port-read memory with a per-word valid flag (so reset frees every frame at once, no
// clearing pass) and a per-word full flag. An item is taken only when the block is idle and
// yields exactly one result item. Allocate scans the full flags sixteen words a cycle, then
// reads the first non-full word and writes it back with its lowest free bit set, returning
// the frame's byte address or status 1 when every frame is used. Reserve and release walk the
// frames the range touches one map word at a time through the same read/modify/write word
// unit: span and limit setup steps, then a read and a write-back per word touched. Frames
// past the end of memory are ignored, an empty range changes nothing, and kind 3 just answers
// zero. A finished result moves into an output register as soon as that register is free;
// the block then accepts the next item while the result waits there to be taken.
module page_frame_bitmap_allocator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pfba_pkg::KIND_W-1:0]    kind,
	input  logic [pfba_pkg::ADDR_W-1:0]    start_addr,
	input  logic [pfba_pkg::ADDR_W-1:0]    end_addr,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pfba_pkg::FA_W-1:0]      frame_addr,
	output logic                           status
);

	pfba_pkg::pfba_state_t state_q, state_d;

	// request
	logic [pfba_pkg::KIND_W-1:0]  kind_q;
	logic [pfba_pkg::ADDR_W-1:0]  start_q;
	logic [pfba_pkg::ADDR_W-1:0]  end_q;
	logic                         nonempty_q;
	logic [pfba_pkg::STEP_W-1:0]  steps_q;

	// walk position
	logic [pfba_pkg::GRP_W-1:0]   grp_q;
	logic [pfba_pkg::WORD_W-1:0]  word_q;
	logic [pfba_pkg::WORD_W-1:0]  first_word_q;
	logic [pfba_pkg::WORD_W-1:0]  last_word_q;
	logic [pfba_pkg::BIT_W-1:0]   first_bit_q;
	logic [pfba_pkg::BIT_W-1:0]   last_bit_q;

	// result and output register
	logic [pfba_pkg::FA_W-1:0]    res_addr_q;
	logic                         res_status_q;
	logic                         out_valid_q;
	logic [pfba_pkg::FA_W-1:0]    frame_addr_q;
	logic                         status_q;

	// map store and word unit
	logic                           rd_en;
	logic                           wr_en;
	pfba_pkg::map_word_t            rd_data;
	pfba_pkg::map_word_t            wr_data;
	logic [pfba_pkg::MAP_WORDS-1:0] full;
	pfba_pkg::pfba_op_t             op;
	logic [pfba_pkg::BIT_W-1:0]     free_bit;

	// combinational helpers
	logic [pfba_pkg::ADDR_W:0]      span;
	logic [pfba_pkg::RNG_W-1:0]     rng_first;
	logic [pfba_pkg::RNG_W-1:0]     rng_last;
	logic [pfba_pkg::RNG_W-1:0]     rng_last_c;
	logic                           rng_skip;
	logic [pfba_pkg::GRP_WORDS-1:0] grp_full;
	logic                           grp_hit;
	logic [pfba_pkg::GRP_SEL_W-1:0] grp_sel;
	logic [31:0]                    alloc_addr;
	logic                           out_load;

	pfba_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (word_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (word_q),
		.wr_data (wr_data),
		.full    (full)
	);

	pfba_word_unit u_word (
		.word_in  (rd_data),
		.op       (op),
		.word_out (wr_data),
		.free_bit (free_bit)
	);

	// Frames touched: page of start through page + steps - 1, clipped at the end of memory.
	assign span       = {1'b0, end_q} - {1'b0, start_q} +
	                    (pfba_pkg::ADDR_W+1)'((1 << pfba_pkg::FRAME_SHIFT) - 1);
	assign rng_first  = pfba_pkg::RNG_W'(start_q[pfba_pkg::ADDR_W-1:pfba_pkg::FRAME_SHIFT]);
	assign rng_last   = rng_first + pfba_pkg::RNG_W'(steps_q) - pfba_pkg::RNG_W'(1);
	assign rng_skip   = !nonempty_q || (rng_first >= pfba_pkg::RNG_W'(pfba_pkg::NUM_FRAMES));
	assign rng_last_c = (rng_last >= pfba_pkg::RNG_W'(pfba_pkg::NUM_FRAMES)) ?
	                    pfba_pkg::RNG_W'(pfba_pkg::NUM_FRAMES - 1) : rng_last;

	// Summary scan: lowest non-full word in the current group of sixteen.
	assign grp_full = full[{grp_q, pfba_pkg::GRP_SEL_W'(0)} +: pfba_pkg::GRP_WORDS];
	always_comb begin
		grp_hit = 1'b0;
		grp_sel = '0;
		for (int i = 0; i < pfba_pkg::GRP_WORDS; i++) begin
			if (!grp_hit && !grp_full[i]) begin
				grp_hit = 1'b1;
				grp_sel = pfba_pkg::GRP_SEL_W'(i);
			end
		end
	end

	// Word unit control; the bit window only narrows in the first and last word of a range.
	always_comb begin
		op.alloc = (kind_q == pfba_pkg::KIND_ALLOC);
		op.set   = (kind_q == pfba_pkg::KIND_RESERVE);
		op.lo    = (word_q == first_word_q) ? first_bit_q : '0;
		op.hi    = (word_q == last_word_q) ? last_bit_q : '1;
	end

	// frame number to byte address, masked to the field width
	assign alloc_addr = 32'({word_q, free_bit}) << pfba_pkg::FRAME_SHIFT;

	assign out_load = (state_q == pfba_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// Sequencer
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		case (state_q)
			pfba_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == pfba_pkg::KIND_ALLOC) begin
						state_d = pfba_pkg::ST_SCAN;
					end else if (kind == pfba_pkg::KIND_RESERVE ||
					             kind == pfba_pkg::KIND_RELEASE) begin
						state_d = pfba_pkg::ST_SPAN;
					end else begin
						state_d = pfba_pkg::ST_DONE;
					end
				end
			end
			pfba_pkg::ST_SPAN: begin
				state_d = pfba_pkg::ST_LIMIT;
			end
			pfba_pkg::ST_LIMIT: begin
				state_d = rng_skip ? pfba_pkg::ST_DONE : pfba_pkg::ST_RD;
			end
			pfba_pkg::ST_SCAN: begin
				if (grp_hit) begin
					state_d = pfba_pkg::ST_RD;
				end else if (grp_q == pfba_pkg::GRP_W'(pfba_pkg::NUM_GRPS - 1)) begin
					state_d = pfba_pkg::ST_DONE;
				end
			end
			pfba_pkg::ST_RD: begin
				rd_en   = 1'b1;
				state_d = pfba_pkg::ST_MOD;
			end
			pfba_pkg::ST_MOD: begin
				wr_en = 1'b1;
				if (op.alloc || word_q == last_word_q) begin
					state_d = pfba_pkg::ST_DONE;
				end else begin
					state_d = pfba_pkg::ST_RD;
				end
			end
			pfba_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = pfba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfba_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			pfba_pkg::ST_IDLE: begin
				kind_q       <= kind;
				start_q      <= start_addr;
				end_q        <= end_addr;
				grp_q        <= '0;
				res_addr_q   <= '0;
				res_status_q <= 1'b0;
			end
			pfba_pkg::ST_SPAN: begin
				nonempty_q <= (start_q < end_q);
				steps_q    <= span[pfba_pkg::ADDR_W:pfba_pkg::FRAME_SHIFT];
			end
			pfba_pkg::ST_LIMIT: begin
				first_word_q <= rng_first[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_W];
				first_bit_q  <= rng_first[pfba_pkg::BIT_W-1:0];
				last_word_q  <= rng_last_c[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_W];
				last_bit_q   <= rng_last_c[pfba_pkg::BIT_W-1:0];
				word_q       <= rng_first[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_W];
			end
			pfba_pkg::ST_SCAN: begin
				if (grp_hit) begin
					word_q <= {grp_q, grp_sel};
				end else if (grp_q == pfba_pkg::GRP_W'(pfba_pkg::NUM_GRPS - 1)) begin
					res_status_q <= 1'b1;
				end else begin
					grp_q <= grp_q + pfba_pkg::GRP_W'(1);
				end
			end
			pfba_pkg::ST_MOD: begin
				if (op.alloc) begin
					res_addr_q <= alloc_addr[pfba_pkg::FA_W-1:0];
				end else if (word_q != last_word_q) begin
					word_q <= word_q + pfba_pkg::WORD_W'(1);
				end
			end
			pfba_pkg::ST_DONE: begin
				if (out_load) begin
					frame_addr_q <= res_addr_q;
					status_q     <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign frame_addr = frame_addr_q;
	assign status     = status_q;

endmodule
